### rtl/cdq_pkg.sv
package cdq_pkg;

    // Command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_PUSH_HEAD = 2'd0,
        CMD_PUSH_TAIL = 2'd1,
        CMD_POP_HEAD  = 2'd2,
        CMD_POP_TAIL  = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_SHIFT_BACK = 2'd1,
        OP_FILL_TAIL  = 2'd2,
        OP_SHIFT_FWD  = 2'd3
    } t_cell_op;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [WORD_W-1:0]  word;
    } t_cell_ctrl;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [WORD_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0]  out_value;
        t_status                   status;
        logic [OCC_W-1:0]          occupancy;
    } t_out;

endpackage

### rtl/circular_deque_unit.sv
// Channel  | Direction | Valid        | Ready        | Payload
// ---------+-----------+--------------+--------------+-------------------------------
// in       | input     | i_in_valid   | o_in_ready   | i_in_data  (cmd, value)
// out      | output    | o_out_valid  | i_out_ready  | o_out_data (out_value, status,
//          |           |              |              |             occupancy)
//
// One transaction enters per cycle unless output stalls; its result is in the output
// register the cycle after acceptance. The front word sits in cell 0; the rear word
// is taken through a DEPTH-way select over the cell row, which sets the cycle path.
// Synchronous active-low reset empties the deque; no clearing pass is needed.
// While a result waits unread, input is held off until the output is taken.
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in_data,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_out  o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]             r_count, n_count;
    logic                      r_out_valid;
    t_out                      r_out;
    t_out                      n_out;
    t_cell_ctrl                cell_ctrl;
    logic                      accept;
    logic signed [WORD_W-1:0]  cell_data [DEPTH];
    logic signed [WORD_W-1:0]  tail_masked [DEPTH];
    logic [DEPTH-1:0]          cell_last;
    logic signed [WORD_W-1:0]  tail_word;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Build the row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] left_data;
        logic signed [WORD_W-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = i_in_data.value;
        end else begin : g_mid
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign right_data = cell_data[g];
        end else begin : g_inner
            assign right_data = cell_data[g+1];
        end

        cdq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_count      (r_count),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .o_data       (cell_data[g]),
            .o_last       (cell_last[g])
        );

        assign tail_masked[g] = cell_last[g] ? cell_data[g] : '0;
    end

    // Select the rear word
    always_comb begin
        tail_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tail_word = tail_word | tail_masked[k];
        end
    end

    // Decode the command into a cell operation and the result
    always_comb begin
        n_count          = r_count;
        cell_ctrl.op     = OP_HOLD;
        cell_ctrl.word   = i_in_data.value;
        n_out.out_value  = '0;
        n_out.status     = STATUS_DONE;
        case (i_in_data.cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                if (r_count == FULL_COUNT) begin
                    n_out.status = STATUS_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    cell_ctrl.op = (i_in_data.cmd == CMD_PUSH_HEAD) ? OP_SHIFT_BACK
                                                                      : OP_FILL_TAIL;
                end
            end
            CMD_POP_HEAD, CMD_POP_TAIL: begin
                if (r_count == '0) begin
                    n_out.status = STATUS_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    if (i_in_data.cmd == CMD_POP_HEAD) begin
                        cell_ctrl.op    = OP_SHIFT_FWD;
                        n_out.out_value = cell_data[0];
                    end else begin
                        n_out.out_value = tail_word;
                    end
                end
            end
            default: n_count = r_count;
        endcase
        n_out.occupancy = OCC_W'(n_count);
        if (!accept) begin
            cell_ctrl.op = OP_HOLD;
        end
    end

    // Advance the count and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/cdq_cell.sv
module cdq_cell
    import cdq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic [CW-1:0]             i_count,
    input  logic signed [WORD_W-1:0]  i_left_data,
    input  logic signed [WORD_W-1:0]  i_right_data,
    output logic signed [WORD_W-1:0]  o_data,
    output logic                      o_last
);

    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

    logic signed [WORD_W-1:0] r_data;

    // Shift with the neighbors or take the pushed word at the first free slot
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_SHIFT_BACK: r_data <= i_left_data;
            OP_SHIFT_FWD:  r_data <= i_right_data;
            OP_FILL_TAIL: begin
                if (i_count == POS) begin
                    r_data <= i_ctrl.word;
                end
            end
            default: r_data <= r_data;
        endcase
    end

    assign o_data = r_data;
    // Flag the rear word of the deque
    assign o_last = (i_count == POS_NEXT);

endmodule

### rtl/cdq_checker.sv
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_ready,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_out  o_out_data
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Block input while an unread result waits
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted over a waiting result");

    // A refused push reports a full deque and no word
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_FULL |->
            o_out_data.occupancy == FULL_OCC && o_out_data.out_value == '0)
        else $error("full refusal with wrong occupancy or word");

    // A refused pop reports an empty deque and no word
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_EMPTY |->
            o_out_data.occupancy == '0 && o_out_data.out_value == '0)
        else $error("empty refusal with wrong occupancy or word");

    // An accepted transaction shows its result in the next cycle
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted transaction produced no result");

endmodule

bind circular_deque_unit cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);

### sim/circular_deque_unit_tb.sv
module circular_deque_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RESET_LEN   = 9;
    localparam int RAND_ITEMS  = 850;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 16;

    // Deque predictor and expected-result store
    class deque_scoreboard;
        logic signed [WORD_W-1:0] cells [DEPTH];
        int unsigned              front_idx;
        int unsigned              back_idx;
        int unsigned              fill;
        t_out                     expected_results [$];
        int unsigned              fails;

        function new();
            front_idx = 0;
            back_idx  = 0;
            fill      = 0;
            fails     = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Apply one accepted transaction to the deque and queue its result
        function void note_input(t_in tr);
            t_out r;
            r.out_value = '0;
            r.status    = STATUS_DONE;
            case (tr.cmd)
                CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                    if (fill >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else if (tr.cmd == CMD_PUSH_HEAD) begin
                        front_idx        = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
                        cells[front_idx] = tr.value;
                        fill++;
                    end else begin
                        cells[back_idx] = tr.value;
                        back_idx        = (back_idx == DEPTH - 1) ? 0 : back_idx + 1;
                        fill++;
                    end
                end
                CMD_POP_HEAD: begin
                    if (fill == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        r.out_value = cells[front_idx];
                        front_idx   = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
                        fill--;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        back_idx    = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
                        r.out_value = cells[back_idx];
                        fill--;
                    end
                end
            endcase
            r.occupancy = fill[OCC_W-1:0];
            expected_results.push_back(r);
        endfunction

        // Compare one delivered result with the oldest expectation
        function void check_result(t_out got);
            t_out exp_r;
            if (expected_results.size() == 0) begin
                $error("result with no transaction pending: out_value %0d status %0d occupancy %0d",
                       got.out_value, got.status, got.occupancy);
                fails++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.out_value !== exp_r.out_value) begin
                $error("out_value: expected %0d, actual %0d", exp_r.out_value, got.out_value);
                fails++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                fails++;
            end
            if (got.occupancy !== exp_r.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", exp_r.occupancy, got.occupancy);
                fails++;
            end
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    deque_scoreboard deque_sb = new();
    int unsigned     idle_cycles = 0;

    circular_deque_unit #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort when no transaction moves on either channel for too long
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic t_in make_cmd(t_cmd c, logic [WORD_W-1:0] v);
        t_in tr;
        tr.cmd   = c;
        tr.value = v;
        return tr;
    endfunction

    // Random word, biased toward the extremes now and then
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Offer one transaction at a clock edge; return at the edge that takes it
    task automatic send_item(input t_in item, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(negedge i_clk); while (o_in_ready !== 1'b1);
        deque_sb.note_input(item);
        @(posedge i_clk);
    endtask

    // Result side: stall at random, check each delivered result
    initial begin
        int unsigned stall;
        int unsigned taken;
        bit          no_stall;
        taken    = 0;
        no_stall = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken % 48 == 0)
                no_stall = ($urandom_range(0, 3) == 0);
            stall = no_stall ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(negedge i_clk); while (o_out_valid !== 1'b1);
            deque_sb.check_result(o_out_data);
            taken++;
            @(posedge i_clk);
        end
    end

    // Stimulus
    initial begin
        logic [WORD_W-1:0] fill_words [4];
        int unsigned       seg_left;
        int unsigned       push_pct;
        bit                no_gap;
        t_cmd              c;
        fill_words[0] = 32'h7fff_ffff;
        fill_words[1] = 32'h8000_0000;
        fill_words[2] = 32'hffff_ffff;
        fill_words[3] = 32'h0000_0000;
        seg_left = 0;
        push_pct = 50;
        no_gap   = 1'b0;

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pops on empty, fill to full from both ends, refused pushes, pops from both ends
        send_item(make_cmd(CMD_POP_HEAD, 32'h1234_5678), 1'b0);
        send_item(make_cmd(CMD_POP_TAIL, 32'hdead_beef), 1'b0);
        for (int k = 0; k < DEPTH; k++) begin
            send_item(make_cmd((k % 2 == 0) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL,
                               (k < 4) ? fill_words[k] : $urandom()), k >= 8);
        end
        send_item(make_cmd(CMD_PUSH_HEAD, 32'h0bad_f00d), 1'b0);
        send_item(make_cmd(CMD_PUSH_TAIL, 32'h0bad_f00d), 1'b1);
        send_item(make_cmd(CMD_POP_HEAD, 32'h0), 1'b0);
        send_item(make_cmd(CMD_POP_TAIL, 32'h0), 1'b1);

        // Random: segments that lean toward filling, draining or churning
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                no_gap = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct)
                c = ($urandom_range(0, 1) == 0) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
            else
                c = ($urandom_range(0, 1) == 0) ? CMD_POP_HEAD : CMD_POP_TAIL;
            send_item(make_cmd(c, pick_word()), no_gap);
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then allow stray ones to show up
        while (deque_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (deque_sb.fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
